// ===== rtl/core/bump_allocator_with_checkpoints_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bump allocator core
// Concurrent assertion wrappers clocked on a rising edge, held off in reset.
// ----------------------------------------------------------------------------
`ifndef BUMP_ALLOCATOR_WITH_CHECKPOINTS_CORE_ASSERT_SVH
`define BUMP_ALLOCATOR_WITH_CHECKPOINTS_CORE_ASSERT_SVH

// same-cycle implication
`define BACC_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bacc assertion failed");

// next-cycle implication
`define BACC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bacc assertion failed");

`endif

// ===== rtl/core/bacc_pkg.sv =====
// ----------------------------------------------------------------------------
// Bump allocator package
// Sizes, codes, word types and helpers shared by the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bacc_pkg;

  localparam int MaxSlots   = 16;
  localparam int OffsetBits = 32;
  localparam int SlotIdxW   = $clog2(MaxSlots);
  localparam int AlnW       = OffsetBits + 13;
  localparam int SumW       = ((AlnW > 32) ? AlnW : 32) + 1;
  localparam logic [31:0] CapMask = (OffsetBits >= 32) ? 32'hFFFF_FFFF
                                  : 32'((64'd1 << OffsetBits) - 64'd1);

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgArenaCapacity = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSlotCount     = 1'd1;

  localparam logic [12:0] DefaultAlignM1 = 13'd7;

  typedef enum logic [1:0] {
    OpAlloc   = 2'd0,
    OpRestore = 2'd1,
    OpReset   = 2'd2,
    OpUnused  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StatusOk      = 3'd0,
    StatusNoSpace = 3'd1,
    StatusRange   = 3'd2,
    StatusTaken   = 3'd3,
    StatusEmpty   = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] request_size;
    logic [12:0] alignment;
    logic [3:0]  checkpoint_id;
  } req_t;

  typedef struct packed {
    logic [31:0] block_offset;
    logic [2:0]  status;
  } rsp_t;

  typedef struct packed {
    logic                rd_en;
    logic [SlotIdxW-1:0] rd_idx;
    logic                wr_en;
    logic [SlotIdxW-1:0] wr_idx;
    logic                clr_all;
  } slot_cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [OffsetBits-1:0] offset;
  } slot_rsp_t;

  function automatic logic [SlotIdxW-1:0] slot_index(input logic [3:0] id);
    slot_index = SlotIdxW'({{SlotIdxW{1'b0}}, id});
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bacc_slot_store.sv =====
// ----------------------------------------------------------------------------
// Checkpoint slot store
// Synchronous offset memory with registered read and per-slot valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bacc_slot_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bacc_pkg::slot_cmd_t                 cmd_i,
  input  logic [bacc_pkg::OffsetBits-1:0]     wr_data_i,
  output bacc_pkg::slot_rsp_t                 rsp_o
);

  logic [bacc_pkg::OffsetBits-1:0] mem [bacc_pkg::MaxSlots];
  logic [bacc_pkg::MaxSlots-1:0]   valid_q;
  logic [bacc_pkg::OffsetBits-1:0] rd_data_q;
  logic                            rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_idx] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[cmd_i.rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_all) begin
        valid_q <= '0;
      end else if (cmd_i.wr_en) begin
        valid_q[cmd_i.wr_idx] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[cmd_i.rd_idx];
      end
    end
  end

  assign rsp_o.valid  = rd_valid_q;
  assign rsp_o.offset = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/bump_allocator_with_checkpoints_core.sv =====
// ----------------------------------------------------------------------------
// Bump allocator with checkpoints
// Hands out aligned offsets from a configured arena; checkpoint slots record
// offsets that a later restore moves the top back to.
// ----------------------------------------------------------------------------
// Usage:
//   Write arena_capacity (index 0) and slot_count (index 1) through the
//   config port while idle; writes take effect at the clock edge.
//   A request word on req_i is taken at an edge with start high and busy low.
//   The accept edge aligns the top and reads the checkpoint slot from the
//   slot memory; busy is then high for one cycle while the result is worked
//   out, the slot written back and the top updated.
//   The result word is registered into rsp_o as busy falls and held until
//   the next result; done_o is high for one cycle with it. busy is low
//   again while done_o is high, so the next request may be given then; no
//   new request is taken while one is worked out (registered slot read).
//   The receiver cannot hold results off and the block never waits on it.
//   Reset clears the top, all slots and both config registers; a reset
//   request clears the top and slots but keeps the config.
// ----------------------------------------------------------------------------
`default_nettype none

module bump_allocator_with_checkpoints_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bacc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [31:0]                      cfg_wdata_i,
  input  logic                             start,
  input  bacc_pkg::req_t                   req_i,
  output logic                             busy,
  output logic                             done_o,
  output bacc_pkg::rsp_t                   rsp_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic                             state_q, state_d;
  logic [31:0]                      cap_q;
  logic [4:0]                       slot_count_q;
  logic [bacc_pkg::OffsetBits-1:0]  top_q, top_d;
  bacc_pkg::req_t                   req_q;
  logic [bacc_pkg::AlnW-1:0]        aligned_q, aligned_d;
  logic                             done_q;
  bacc_pkg::rsp_t                   rsp_q, rsp_d;

  logic                             accept;
  logic [12:0]                      align_m1;
  logic [bacc_pkg::AlnW-1:0]        rounded;
  logic [bacc_pkg::SumW-1:0]        total;
  logic [bacc_pkg::SumW-1:0]        cap_eff;
  logic                             no_space;
  logic                             id_zero;
  logic                             id_range;
  bacc_pkg::slot_cmd_t              slot_cmd;
  bacc_pkg::slot_rsp_t              slot_rsp;

  assign busy   = (state_q == StExec);
  assign accept = start && !busy;

  // round the top up to the alignment
  assign align_m1  = (req_i.alignment == 13'd0) ? bacc_pkg::DefaultAlignM1
                                                : req_i.alignment - 13'd1;
  assign rounded   = bacc_pkg::AlnW'(top_q) + bacc_pkg::AlnW'(align_m1);
  assign aligned_d = rounded & ~bacc_pkg::AlnW'(align_m1);

  assign total    = bacc_pkg::SumW'(aligned_q) + bacc_pkg::SumW'(req_q.request_size);
  assign cap_eff  = bacc_pkg::SumW'(cap_q & bacc_pkg::CapMask);
  assign no_space = total > cap_eff;
  assign id_zero  = (req_q.checkpoint_id == 4'd0);
  assign id_range = ({28'd0, req_q.checkpoint_id} >= 32'(slot_count_q))
                 || ({28'd0, req_q.checkpoint_id} >= 32'(bacc_pkg::MaxSlots));

  always_comb begin
    state_d          = state_q;
    top_d            = top_q;
    rsp_d            = '0;
    slot_cmd.rd_en   = 1'b0;
    slot_cmd.rd_idx  = bacc_pkg::slot_index(req_i.checkpoint_id);
    slot_cmd.wr_en   = 1'b0;
    slot_cmd.wr_idx  = bacc_pkg::slot_index(req_q.checkpoint_id);
    slot_cmd.clr_all = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          slot_cmd.rd_en = 1'b1;
          state_d        = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
        case (req_q.operation)
          bacc_pkg::OpAlloc: begin
            if (no_space) begin
              rsp_d.status = bacc_pkg::StatusNoSpace;
            end else if (!id_zero && id_range) begin
              rsp_d.status = bacc_pkg::StatusRange;
            end else if (!id_zero && slot_rsp.valid) begin
              rsp_d.status = bacc_pkg::StatusTaken;
            end else begin
              slot_cmd.wr_en     = !id_zero;
              top_d              = bacc_pkg::OffsetBits'(total);
              rsp_d.block_offset = 32'(aligned_q);
              rsp_d.status       = bacc_pkg::StatusOk;
            end
          end
          bacc_pkg::OpRestore: begin
            if (id_zero || id_range) begin
              rsp_d.status = bacc_pkg::StatusRange;
            end else if (!slot_rsp.valid) begin
              rsp_d.status = bacc_pkg::StatusEmpty;
            end else begin
              top_d              = slot_rsp.offset;
              rsp_d.block_offset = 32'(slot_rsp.offset);
              rsp_d.status       = bacc_pkg::StatusOk;
            end
          end
          bacc_pkg::OpReset: begin
            top_d            = '0;
            slot_cmd.clr_all = 1'b1;
            rsp_d.status     = bacc_pkg::StatusOk;
          end
          default: begin
            rsp_d.status = bacc_pkg::StatusOk;
          end
        endcase
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      top_q        <= '0;
      cap_q        <= '0;
      slot_count_q <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      done_q  <= (state_q == StExec);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bacc_pkg::CfgArenaCapacity: cap_q        <= cfg_wdata_i;
          bacc_pkg::CfgSlotCount:     slot_count_q <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_i;
      aligned_q <= aligned_d;
    end
    if (state_q == StExec) begin
      rsp_q <= rsp_d;
    end
  end

  bacc_slot_store u_slot_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (slot_cmd),
    .wr_data_i (bacc_pkg::OffsetBits'(aligned_q)),
    .rsp_o     (slot_rsp)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/bacc_checker.sv =====
// ----------------------------------------------------------------------------
// Bump allocator port checker
// Watches the core's ports for request/result sequencing and error results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bump_allocator_with_checkpoints_core_assert.svh"

module bacc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input bacc_pkg::req_t               req_i,
  input logic                         busy,
  input logic                         done_o,
  input bacc_pkg::rsp_t               rsp_o
);

  logic err_word;

  assign err_word = (rsp_o.status != bacc_pkg::StatusOk);

  `BACC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy && !done_o)
  `BACC_ASSERT_NEXT(a_busy_done, clk_i, rst_ni, busy, done_o && !busy)
  `BACC_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `BACC_ASSERT_NOW(a_err_zero, clk_i, rst_ni, done_o && err_word, rsp_o.block_offset == 32'd0)

endmodule

bind bump_allocator_with_checkpoints_core bacc_checker u_bacc_checker (.*);

`default_nettype wire

// ===== verif/bacc_result_checker.sv =====
// ----------------------------------------------------------------------------
// Bump allocator result checker
// Watches the config port, the request channel and the result channel. Keeps
// its own copy of the arena top, the checkpoint slots and both registers,
// works out the result word for every accepted request and compares each
// returned word, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module bacc_result_checker
  import bacc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                start_i,
  input  logic                busy_i,
  input  req_t                req_i,
  input  logic                done_i,
  input  rsp_t                rsp_i,
  output int                  pending_o,
  output int                  fail_count_o
);

  logic [31:0] arena_cap;
  logic [4:0]  slot_cnt;
  logic [31:0] arena_top;
  logic        slot_used [MaxSlots];
  logic [31:0] slot_off  [MaxSlots];
  rsp_t        result_q  [$];

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (fail_count_o < 100)
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic clear_slots();
    for (int i = 0; i < MaxSlots; i++) begin
      slot_used[i] = 1'b0;
      slot_off[i]  = '0;
    end
  endtask

  // next result word and state update for one request
  task automatic apply_request(input req_t r, output rsp_t res);
    logic [63:0] aln;
    logic [63:0] base;
    logic [63:0] sum;
    int          live;
    int          id;
    live = (slot_cnt > MaxSlots) ? MaxSlots : int'(slot_cnt);
    id   = int'(r.checkpoint_id);
    res  = '{block_offset: '0, status: StatusOk};
    case (op_e'(r.operation))
      OpAlloc: begin
        aln  = (r.alignment == '0) ? 64'd8 : {51'd0, r.alignment};
        base = ({32'd0, arena_top} + aln - 64'd1) & ~(aln - 64'd1);
        sum  = base + {32'd0, r.request_size};
        if (sum > {32'd0, arena_cap}) begin
          res.status = StatusNoSpace;
        end else if (id != 0 && id >= live) begin
          res.status = StatusRange;
        end else if (id != 0 && slot_used[id]) begin
          res.status = StatusTaken;
        end else begin
          if (id != 0) begin
            slot_used[id] = 1'b1;
            slot_off[id]  = base[31:0];
          end
          arena_top        = sum[31:0];
          res.block_offset = base[31:0];
        end
      end
      OpRestore: begin
        if (id == 0 || id >= live) begin
          res.status = StatusRange;
        end else if (!slot_used[id]) begin
          res.status = StatusEmpty;
        end else begin
          arena_top        = slot_off[id];
          res.block_offset = slot_off[id];
        end
      end
      OpReset: begin
        arena_top = '0;
        clear_slots();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    rsp_t next_word;
    if (!rst_ni) begin
      arena_cap = '0;
      slot_cnt  = '0;
      arena_top = '0;
      clear_slots();
      result_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (done_i) begin
        if (result_q.size() == 0) begin
          flag_mismatch("unexpected result word, offset", rsp_i.block_offset, '0);
        end else begin
          want = result_q.pop_front();
          if (rsp_i.block_offset !== want.block_offset)
            flag_mismatch("block_offset", rsp_i.block_offset, want.block_offset);
          if (rsp_i.status !== want.status)
            flag_mismatch("status", {29'd0, rsp_i.status}, {29'd0, want.status});
        end
      end
      if (start_i && !busy_i) begin
        apply_request(req_i, next_word);
        result_q.push_back(next_word);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgArenaCapacity: arena_cap = cfg_wdata_i;
          CfgSlotCount:     slot_cnt  = cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      pending_o = result_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Bump allocator testbench
// Drives directed and random request words with random gaps into the core,
// rewrites capacity and slot count between phases while idle, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 86;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [bacc_pkg::CfgIdxW-1:0] cfg_idx;
  logic [31:0]                  cfg_wdata;
  logic                         start;
  bacc_pkg::req_t               req;
  logic                         busy;
  logic                         done;
  bacc_pkg::rsp_t               rsp;
  int                           pending;
  int                           fail_count;
  int                           cycle_count;
  bit                           burst;
  int                           live_ids;

  bump_allocator_with_checkpoints_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .start       (start),
    .req_i       (req),
    .busy        (busy),
    .done_o      (done),
    .rsp_o       (rsp)
  );

  bacc_result_checker alloc_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .rsp_i        (rsp),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bump_allocator_with_checkpoints_core: mismatch");
    $finish;
  end

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bacc_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] data);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // one request word: random gap (none in burst), then hold start until taken
  task automatic issue(input bacc_pkg::op_e op, input logic [31:0] size,
                       input logic [12:0] aln, input logic [3:0] id);
    int gap;
    bit taken;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) begin
        req = '{operation: 2'($urandom), request_size: $urandom,
                alignment: 13'($urandom), checkpoint_id: 4'($urandom)};
        @(negedge clk);
      end
    end
    req   = '{operation: op, request_size: size, alignment: aln, checkpoint_id: id};
    start = 1'b1;
    do begin
      taken = !busy;
      @(negedge clk);
    end while (!taken);
    start = 1'b0;
  endtask

  initial begin
    bacc_pkg::op_e op;
    logic [31:0]   size;
    logic [12:0]   aln;
    logic [3:0]    id;
    int            roll;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = bacc_pkg::CfgArenaCapacity;
    cfg_wdata = '0;
    start     = 1'b0;
    req       = '0;
    burst     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero capacity, no slots
    issue(bacc_pkg::OpAlloc, 32'd0, 13'd0, 4'd0);
    issue(bacc_pkg::OpAlloc, 32'd1, 13'd0, 4'd0);
    issue(bacc_pkg::OpRestore, 32'd0, 13'd0, 4'd1);

    write_reg(bacc_pkg::CfgArenaCapacity, 32'd4096);
    write_reg(bacc_pkg::CfgSlotCount, 32'd16);
    issue(bacc_pkg::OpAlloc, 32'd5, 13'd0, 4'd1);
    issue(bacc_pkg::OpAlloc, 32'd3, 13'd16, 4'd2);
    issue(bacc_pkg::OpAlloc, 32'd1, 13'd4096, 4'd3);
    issue(bacc_pkg::OpAlloc, 32'd0, 13'd4096, 4'd0);
    issue(bacc_pkg::OpAlloc, 32'd0, 13'd3, 4'd0);
    issue(bacc_pkg::OpAlloc, 32'd0, 13'd0, 4'd1);
    issue(bacc_pkg::OpAlloc, 32'd0, 13'd0, 4'd15);
    issue(bacc_pkg::OpRestore, 32'd0, 13'd0, 4'd0);
    issue(bacc_pkg::OpRestore, 32'd0, 13'd0, 4'd4);
    issue(bacc_pkg::OpRestore, 32'd0, 13'd0, 4'd2);
    issue(bacc_pkg::OpAlloc, 32'hFFFF_FFFF, 13'h1FFF, 4'd0);
    issue(bacc_pkg::OpUnused, 32'hFFFF_FFFF, 13'h1FFF, 4'hF);
    issue(bacc_pkg::OpRestore, 32'd0, 13'd0, 4'd15);
    issue(bacc_pkg::OpReset, 32'd0, 13'd0, 4'd0);
    issue(bacc_pkg::OpRestore, 32'd0, 13'd0, 4'd1);

    write_reg(bacc_pkg::CfgArenaCapacity, 32'hFFFF_FFFF);
    write_reg(bacc_pkg::CfgSlotCount, 32'd31);
    issue(bacc_pkg::OpAlloc, 32'hFFFF_FFFF, 13'd0, 4'd15);
    issue(bacc_pkg::OpAlloc, 32'd0, 13'd0, 4'd0);
    issue(bacc_pkg::OpReset, 32'd0, 13'd0, 4'd0);

    write_reg(bacc_pkg::CfgSlotCount, 32'd2);
    issue(bacc_pkg::OpAlloc, 32'd700, 13'd1, 4'd1);
    issue(bacc_pkg::OpAlloc, 32'd1, 13'd0, 4'd2);
    issue(bacc_pkg::OpRestore, 32'd0, 13'd0, 4'd2);

    // capacity dropped below the top
    write_reg(bacc_pkg::CfgArenaCapacity, 32'd100);
    issue(bacc_pkg::OpAlloc, 32'd0, 13'd0, 4'd0);
    issue(bacc_pkg::OpRestore, 32'd0, 13'd0, 4'd1);
    issue(bacc_pkg::OpAlloc, 32'd10, 13'd0, 4'd0);
    issue(bacc_pkg::OpReset, 32'd0, 13'd0, 4'd0);

    for (int ph = 0; ph < 12; ph++) begin
      start = 1'b0;
      case ($urandom_range(0, 5))
        0:       write_reg(bacc_pkg::CfgArenaCapacity, $urandom_range(0, 64));
        4:       write_reg(bacc_pkg::CfgArenaCapacity, $urandom);
        5:       write_reg(bacc_pkg::CfgArenaCapacity, 32'hFFFF_FFFF);
        default: write_reg(bacc_pkg::CfgArenaCapacity, $urandom_range(4096, 65535));
      endcase
      case ($urandom_range(0, 5))
        0:       live_ids = 0;
        1:       live_ids = 1;
        2:       live_ids = 31;
        3:       live_ids = $urandom_range(2, 31);
        default: live_ids = 16;
      endcase
      write_reg(bacc_pkg::CfgSlotCount, 32'(live_ids));
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseItems; n++) begin
        roll = $urandom_range(0, 99);
        op = (roll < 60) ? bacc_pkg::OpAlloc : (roll < 88) ? bacc_pkg::OpRestore
           : (roll < 94) ? bacc_pkg::OpReset : bacc_pkg::OpUnused;
        case ($urandom_range(0, 9))
          7:       size = $urandom_range(0, 65535);
          8:       size = $urandom;
          9:       size = '0;
          default: size = $urandom_range(0, 255);
        endcase
        roll = $urandom_range(0, 9);
        if (roll < 7)      aln = 13'(1) << $urandom_range(0, 12);
        else if (roll < 8) aln = '0;
        else               aln = 13'($urandom);
        roll = $urandom_range(0, 9);
        if (roll < 3 && op == bacc_pkg::OpAlloc) id = '0;
        else if (roll < 8 && live_ids > 1)
          id = 4'($urandom_range(1, (live_ids > 16) ? 15 : live_ids - 1));
        else                                     id = 4'($urandom);
        issue(op, size, aln, id);
      end
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("bump_allocator_with_checkpoints_core: match");
    end else begin
      $display("bump_allocator_with_checkpoints_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bacc_pkg.sv
rtl/core/bacc_slot_store.sv
rtl/core/bump_allocator_with_checkpoints_core.sv
rtl/core/bacc_checker.sv
verif/bacc_result_checker.sv
verif/testbench.sv
